// ===== rtl/core/sacl_pkg.sv =====
`timescale 1ns / 1ps
package sacl_pkg;

  // Tag store geometry.
  localparam int unsigned MAX_SETS = 256;
  localparam int unsigned MAX_WAYS = 8;
  localparam int unsigned SET_W    = $clog2(MAX_SETS);
  localparam int unsigned WAY_W    = $clog2(MAX_WAYS);
  localparam int unsigned TAG_W    = 30;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned CYC_W    = 18;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRITE_ALLOCATE = 8'd0,
    CFG_WRITE_BACK     = 8'd1,
    CFG_OFFSET_WIDTH   = 8'd2,
    CFG_INDEX_WIDTH    = 8'd3,
    CFG_WAYS_IN_USE    = 8'd4
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_WRITE
  } state_e;

  // Access request.
  typedef struct packed {
    logic        cmd;
    logic [31:0] address;
  } req_t;

  // Access result.
  typedef struct packed {
    logic             hit;
    logic [2:0]       way_used;
    logic             dirty_evicted;
    logic [CYC_W-1:0] access_cycles;
  } rsp_t;

  // One line of the tag store.
  typedef struct packed {
    logic               valid;
    logic               dirty;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  // Running outcome of the way scan.
  typedef struct packed {
    logic               found;
    logic [WAY_W-1:0]   found_way;
    logic               has_inv;
    logic [WAY_W-1:0]   inv_way;
    logic [STAMP_W-1:0] min_stamp;
    logic [WAY_W-1:0]   min_way;
  } scan_t;

endpackage

// ===== rtl/core/set_assoc_cache_lru_model.sv =====
`timescale 1ns / 1ps
// Tag store of a set-associative LRU cache with write-back or write-through
// and write-allocate options. After reset the block sweeps its 256-row set
// memory with busy_o high, then takes a transaction when start_i is high and
// busy_o is low. Each transaction steps through accepting it, reading the set
// row, visiting the ways in use one at a time through a single shared
// tag/stamp compare unit, and writing the row back if it changed. The result
// appears on rsp_o with rsp_valid_o high for exactly one cycle and cannot be
// stalled. Configuration writes take effect at the next clock edge and must
// only be made while no transaction is in flight.
module set_assoc_cache_lru_model
  import sacl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  req_t                 req_i,
  output logic                 rsp_valid_o,
  output rsp_t                 rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i
);

  state_e state_q, state_d;

  logic       wa_q, wb_q;
  logic [3:0] off_cfg_q, iw_cfg_q, ways_cfg_q;

  logic [SET_W-1:0]   cnt_q, cnt_d;
  logic [WAY_W-1:0]   way_q, way_d;
  logic [STAMP_W-1:0] clock_q, clock_d;
  logic               cmd_q;
  logic [SET_W-1:0]   set_q;
  logic [TAG_W-1:0]   tag_q;

  logic [3:0]  off_sat, iw_sat, ways_sat;
  logic [4:0]  shamt;
  logic [31:0] idx_bits;
  logic [11:0] idx_mask;
  logic [31:0] tag_full;
  logic [WAY_W-1:0] last_way;
  logic [10:0] blk;
  logic [CYC_W-1:0] xfer;

  logic       mem_we, mem_re;
  logic [SET_W-1:0] mem_waddr;
  row_t       mem_wdata, rdata;
  scan_t      scan;
  logic       scan_en, scan_first;

  logic       accept;
  logic       store_op;
  logic       victim_dirty;
  logic [WAY_W-1:0] victim;
  line_t      new_line;
  rsp_t       rsp;
  logic       do_write;

  assign accept = (state_q == ST_IDLE) && start_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_q       <= 1'b1;
      wb_q       <= 1'b1;
      off_cfg_q  <= 4'd4;
      iw_cfg_q   <= 4'd8;
      ways_cfg_q <= 4'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WRITE_ALLOCATE: wa_q       <= cfg_wdata_i[0];
        CFG_WRITE_BACK:     wb_q       <= cfg_wdata_i[0];
        CFG_OFFSET_WIDTH:   off_cfg_q  <= cfg_wdata_i;
        CFG_INDEX_WIDTH:    iw_cfg_q   <= cfg_wdata_i;
        CFG_WAYS_IN_USE:    ways_cfg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Saturated geometry and block transfer cost.
  always_comb begin
    off_sat  = (off_cfg_q < 4'd2) ? 4'd2 : ((off_cfg_q > 4'd12) ? 4'd12 : off_cfg_q);
    iw_sat   = (iw_cfg_q > 4'd12) ? 4'd12 : iw_cfg_q;
    ways_sat = (ways_cfg_q < 4'd1) ? 4'd1 :
               ((ways_cfg_q > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : ways_cfg_q);
    last_way = WAY_W'(ways_sat - 4'd1);
    shamt    = 5'(off_sat) + 5'(iw_sat);
    idx_bits = req_i.address >> off_sat;
    idx_mask = 12'((13'd1 << iw_sat) - 13'd1);
    tag_full = req_i.address >> shamt;
    blk      = 11'd1 << (off_sat - 4'd2);
    // Transfer cost is block words times 100, as 64 + 32 + 4.
    xfer     = (CYC_W'(blk) << 6) + (CYC_W'(blk) << 5) + (CYC_W'(blk) << 2);
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    way_d      = way_q;
    mem_re     = 1'b0;
    scan_en    = 1'b0;
    scan_first = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SET_W'(MAX_SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        way_d   = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        scan_en    = 1'b1;
        scan_first = (way_q == '0);
        way_d      = way_q + 1'b1;
        if (way_q == last_way) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      way_q   <= '0;
      clock_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      way_q   <= way_d;
      if (accept) begin
        clock_q <= clock_d;
      end
    end
  end

  assign clock_d = clock_q + 1'b1;

  // Transaction fields latched at accept.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i.cmd;
      set_q <= SET_W'(idx_bits[11:0] & idx_mask);
      tag_q <= tag_full[TAG_W-1:0];
    end
  end

  sacl_row_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (set_q),
    .rdata_o (rdata)
  );

  sacl_way_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (scan_en),
    .first_i (scan_first),
    .way_i   (way_q),
    .line_i  (rdata[way_q]),
    .tag_i   (tag_q),
    .scan_o  (scan)
  );

  // Hit, allocation and cost decision in the write cycle.
  always_comb begin
    store_op     = cmd_q;
    victim       = scan.has_inv ? scan.inv_way : scan.min_way;
    victim_dirty = !scan.has_inv && wb_q && rdata[scan.min_way].dirty;
    new_line     = '0;
    rsp          = '0;
    do_write     = 1'b0;
    mem_wdata    = rdata;
    if (scan.found) begin
      do_write       = 1'b1;
      new_line       = rdata[scan.found_way];
      new_line.stamp = clock_q;
      if (store_op && wb_q) begin
        new_line.dirty = 1'b1;
      end
      mem_wdata[scan.found_way] = new_line;
      rsp.hit           = 1'b1;
      rsp.way_used      = 3'(scan.found_way);
      rsp.access_cycles = (store_op && !wb_q) ? CYC_W'(101) : CYC_W'(1);
    end else if (store_op && !wa_q) begin
      rsp.access_cycles = CYC_W'(100);
    end else begin
      do_write       = 1'b1;
      new_line.valid = 1'b1;
      new_line.dirty = store_op && wb_q;
      new_line.tag   = tag_q;
      new_line.stamp = clock_q;
      mem_wdata[victim] = new_line;
      rsp.way_used      = 3'(victim);
      rsp.dirty_evicted = victim_dirty;
      rsp.access_cycles = xfer + (victim_dirty ? xfer : CYC_W'(0)) +
                          ((store_op && !wb_q) ? CYC_W'(101) : CYC_W'(1));
    end
    // The clearing sweep shares the write port.
    if (state_q == ST_CLEAR) begin
      mem_wdata = '0;
    end
  end

  assign mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_WRITE) && do_write);
  assign mem_waddr = (state_q == ST_CLEAR) ? cnt_q : set_q;

  assign busy_o      = (state_q != ST_IDLE);
  assign rsp_valid_o = (state_q == ST_WRITE);
  assign rsp_o       = rsp;

endmodule

// ===== rtl/core/sacl_row_mem.sv =====
`timescale 1ns / 1ps
module sacl_row_mem
  import sacl_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [SET_W-1:0] waddr_i,
  input  row_t             wdata_i,
  input  logic             re_i,
  input  logic [SET_W-1:0] raddr_i,
  output row_t             rdata_o
);

  row_t mem [MAX_SETS];
  row_t rdata_q;

  // One row per set; write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sacl_way_scan.sv =====
`timescale 1ns / 1ps
module sacl_way_scan
  import sacl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             first_i,
  input  logic [WAY_W-1:0] way_i,
  input  line_t            line_i,
  input  logic [TAG_W-1:0] tag_i,
  output scan_t            scan_o
);

  scan_t scan_q;
  scan_t scan_d;
  logic  match;

  assign match = line_i.valid && (line_i.tag == tag_i);

  // One way per enabled cycle: first tag match, first invalid way, oldest stamp.
  always_comb begin
    scan_d = scan_q;
    if (first_i) begin
      scan_d.found     = match;
      scan_d.found_way = way_i;
      scan_d.has_inv   = !line_i.valid;
      scan_d.inv_way   = way_i;
      scan_d.min_stamp = line_i.stamp;
      scan_d.min_way   = way_i;
    end else begin
      if (!scan_q.found && match) begin
        scan_d.found     = 1'b1;
        scan_d.found_way = way_i;
      end
      if (!scan_q.has_inv && !line_i.valid) begin
        scan_d.has_inv = 1'b1;
        scan_d.inv_way = way_i;
      end
      if (line_i.stamp < scan_q.min_stamp) begin
        scan_d.min_stamp = line_i.stamp;
        scan_d.min_way   = way_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else if (en_i) begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule

// ===== rtl/core/sacl_checker.sv =====
`timescale 1ns / 1ps
module sacl_checker
  import sacl_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic rsp_valid_o,
  input rsp_t rsp_o
);

  // An accepted transaction makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accept");

  // A result is only shown while a transaction is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> busy_o)
    else $error("result while idle");

  // Each transaction gives one result cycle, then the block is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> (!rsp_valid_o && !busy_o))
    else $error("result strobe longer than one cycle");

  // A hit reports one of its two access costs; a miss reports no less than a no-allocate store miss.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.hit ?
      (rsp_o.access_cycles == 18'd1 || rsp_o.access_cycles == 18'd101) :
      (rsp_o.access_cycles >= 18'd100)))
    else $error("access cost out of range");

endmodule

bind set_assoc_cache_lru_model sacl_checker u_sacl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import sacl_pkg::*;

  localparam int unsigned LINES     = MAX_SETS * MAX_WAYS;
  localparam int unsigned WDOG_MAX  = 5000;
  localparam int unsigned TAIL_WAIT = 20;
  // An index that names no register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd9;

  typedef enum logic [1:0] {
    ITEM_ACCESS,
    ITEM_CONFIG,
    ITEM_DRAIN
  } item_kind_e;

  typedef struct {
    item_kind_e             kind;
    req_t                   req;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DAT_W-1:0]   data;
    int                     gap_pct;
  } pending_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  req_t                 req_i;
  logic                 rsp_valid_o;
  rsp_t                 rsp_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;

  set_assoc_cache_lru_model i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Mirror of the tag store and its configuration.
  logic                 line_valid_m [LINES];
  logic                 line_dirty_m [LINES];
  logic [TAG_W-1:0]     line_tag_m   [LINES];
  logic [STAMP_W-1:0]   line_stamp_m [LINES];
  logic [STAMP_W-1:0]   use_clock;
  logic                 alloc_on;
  logic                 wback_on;
  logic [3:0]           offset_reg;
  logic [3:0]           index_reg;
  logic [3:0]           ways_reg;

  pending_t pending_q[$];
  rsp_t     expected_rsp_q[$];
  int       error_count;
  int       quiet_cycles;
  int       idle_cycles;
  logic     req_taken;
  logic     drv_start;
  logic     drv_we;
  logic     block_quiet;
  pending_t head;

  // Stimulus-side copy of the geometry, used to shape addresses.
  int unsigned gen_off;
  int unsigned gen_iw;

  // Computes the outcome of one access and updates the mirrored tag store.
  function automatic rsp_t cache_lookup(input req_t r);
    int unsigned off, iw, ways, set_n, base, xfer, cyc, w, k;
    logic [31:0] tag;
    int          found, target;
    logic [STAMP_W-1:0] best;
    rsp_t        res;
    off   = offset_reg < 2 ? 2 : (offset_reg > 12 ? 12 : offset_reg);
    iw    = index_reg > 12 ? 12 : index_reg;
    ways  = ways_reg < 1 ? 1 : (ways_reg > MAX_WAYS ? MAX_WAYS : ways_reg);
    use_clock = use_clock + 1;
    set_n = ((r.address >> off) & ((32'd1 << iw) - 1)) % MAX_SETS;
    tag   = r.address >> (off + iw);
    base  = set_n * MAX_WAYS;
    xfer  = ((32'd1 << off) / 4) * 100;
    found = -1;
    res   = '0;
    cyc   = 0;
    for (w = 0; w < ways; w++) begin
      if (found < 0 && line_valid_m[base+w] && line_tag_m[base+w] == tag[TAG_W-1:0]
          && tag[31:TAG_W] == 2'b00) begin
        found = w;
      end
    end
    if (found >= 0) begin
      k = base + found;
      res.hit = 1'b1;
      res.way_used = found[2:0];
      line_stamp_m[k] = use_clock;
      if (r.cmd && wback_on) begin
        line_dirty_m[k] = 1'b1;
        cyc = 1;
      end else if (r.cmd) begin
        cyc = 101;
      end else begin
        cyc = 1;
      end
    end else if (r.cmd && !alloc_on) begin
      cyc = 100;
    end else begin
      cyc = xfer;
      target = -1;
      for (w = 0; w < ways; w++) begin
        if (target < 0 && !line_valid_m[base+w]) target = w;
      end
      if (target < 0) begin
        // Full set: least recently used way, lowest way on a tie.
        best = line_stamp_m[base];
        target = 0;
        for (w = 1; w < ways; w++) begin
          if (line_stamp_m[base+w] < best) begin
            best = line_stamp_m[base+w];
            target = w;
          end
        end
        if (wback_on && line_dirty_m[base+target]) begin
          cyc += xfer;
          res.dirty_evicted = 1'b1;
        end
      end
      k = base + target;
      res.way_used = target[2:0];
      line_valid_m[k] = 1'b1;
      line_tag_m[k]   = tag[TAG_W-1:0];
      line_stamp_m[k] = use_clock;
      line_dirty_m[k] = r.cmd && wback_on;
      cyc += (r.cmd && !wback_on) ? 101 : 1;
    end
    res.access_cycles = cyc[CYC_W-1:0];
    return res;
  endfunction

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Monitor: records accepted requests and config writes, checks results.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_taken    <= 1'b0;
      quiet_cycles <= 0;
      idle_cycles  <= 0;
      use_clock    = '0;
      alloc_on     = 1'b1;
      wback_on     = 1'b1;
      offset_reg   = 4'd4;
      index_reg    = 4'd8;
      ways_reg     = 4'd8;
      for (int i = 0; i < LINES; i++) begin
        line_valid_m[i] = 1'b0;
        line_dirty_m[i] = 1'b0;
        line_tag_m[i]   = '0;
        line_stamp_m[i] = '0;
      end
    end else begin
      req_taken <= start_i && !busy_o;
      if (start_i && !busy_o) expected_rsp_q.push_back(cache_lookup(req_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WRITE_ALLOCATE: alloc_on   = cfg_wdata_i[0];
          CFG_WRITE_BACK:     wback_on   = cfg_wdata_i[0];
          CFG_OFFSET_WIDTH:   offset_reg = cfg_wdata_i;
          CFG_INDEX_WIDTH:    index_reg  = cfg_wdata_i;
          CFG_WAYS_IN_USE:    ways_reg   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (rsp_valid_o) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result transaction with no access outstanding");
          error_count++;
        end else begin
          rsp_t exp_rsp;
          exp_rsp = expected_rsp_q.pop_front();
          if (rsp_o.hit !== exp_rsp.hit) begin
            $error("hit: expected %0d, got %0d", exp_rsp.hit, rsp_o.hit);
            error_count++;
          end
          if (rsp_o.way_used !== exp_rsp.way_used) begin
            $error("way_used: expected %0d, got %0d", exp_rsp.way_used, rsp_o.way_used);
            error_count++;
          end
          if (rsp_o.dirty_evicted !== exp_rsp.dirty_evicted) begin
            $error("dirty_evicted: expected %0d, got %0d",
                   exp_rsp.dirty_evicted, rsp_o.dirty_evicted);
            error_count++;
          end
          if (rsp_o.access_cycles !== exp_rsp.access_cycles) begin
            $error("access_cycles: expected %0d, got %0d",
                   exp_rsp.access_cycles, rsp_o.access_cycles);
            error_count++;
          end
        end
      end
      quiet_cycles <= (rsp_valid_o || (start_i && !busy_o)) ? 0 : quiet_cycles + 1;
      idle_cycles  <= (rsp_valid_o || (start_i && !busy_o) || cfg_we_i) ? 0 : idle_cycles + 1;
    end
  end

  // Driver: feeds accesses and config writes from the pending queue.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      drv_start   = start_i && !req_taken;
      drv_we      = 1'b0;
      block_quiet = expected_rsp_q.size() == 0 && !busy_o && quiet_cycles >= 4;
      if (!drv_start && pending_q.size() > 0) begin
        head = pending_q[0];
        case (head.kind)
          ITEM_ACCESS: begin
            if ($urandom_range(0, 99) >= head.gap_pct) begin
              drv_start = 1'b1;
              req_i <= head.req;
              void'(pending_q.pop_front());
            end
          end
          ITEM_CONFIG: begin
            if (block_quiet) begin
              drv_we = 1'b1;
              cfg_idx_i   <= head.idx;
              cfg_wdata_i <= head.data;
              void'(pending_q.pop_front());
            end
          end
          default: begin
            if (block_quiet) void'(pending_q.pop_front());
          end
        endcase
      end
      start_i  <= drv_start;
      cfg_we_i <= drv_we;
    end
  end

  // Watchdog on cycles without any accepted transaction, result or config write.
  always @(posedge clk_i) begin
    if (idle_cycles >= WDOG_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_access(input logic cmd, input logic [31:0] addr, input int gap);
    pending_t it;
    it = '{kind: ITEM_ACCESS, req: '{cmd: cmd, address: addr}, idx: '0, data: '0,
           gap_pct: gap};
    pending_q.push_back(it);
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    pending_t it;
    it = '{kind: ITEM_CONFIG, req: '0, idx: idx, data: val, gap_pct: 0};
    pending_q.push_back(it);
    if (idx == CFG_OFFSET_WIDTH) gen_off = val < 2 ? 2 : (val > 12 ? 12 : val);
    if (idx == CFG_INDEX_WIDTH)  gen_iw  = val > 12 ? 12 : val;
  endtask

  // Address built from a small pool of tags and sets so lines get reused.
  function automatic logic [31:0] pooled_addr();
    logic [31:0] a;
    a = ($urandom_range(0, 9) << (gen_off + gen_iw))
      | ($urandom_range(0, 3) << gen_off)
      | ($urandom & ((32'd1 << gen_off) - 1));
    return a;
  endfunction

  initial begin
    pending_t drain_it;
    int gap;
    error_count = 0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    gen_off     = 4;
    gen_iw      = 8;
    drain_it    = '{kind: ITEM_DRAIN, req: '0, idx: '0, data: '0, gap_pct: 0};

    // Directed: miss then hits, address extremes.
    push_access(1'b0, 32'h0000_0000, 0);
    push_access(1'b0, 32'h0000_0004, 0);
    push_access(1'b1, 32'h0000_0008, 0);
    push_access(1'b0, 32'hFFFF_FFFF, 0);
    push_access(1'b1, 32'h8000_0000, 0);
    // Two-way set: LRU replacement and a dirty eviction.
    push_cfg(CFG_WAYS_IN_USE, 4'd2);
    push_access(1'b0, 32'h0000_1000, 0);
    push_access(1'b0, 32'h0000_2000, 0);
    push_access(1'b1, 32'h0000_1000, 0);
    push_access(1'b0, 32'h0000_3000, 0);
    push_access(1'b0, 32'h0000_4000, 0);
    push_access(1'b1, 32'h0000_3000, 0);
    // Write-through: store hit, dirty victim dropped without write-back.
    push_cfg(CFG_WRITE_BACK, 4'd0);
    push_access(1'b1, 32'h0000_3000, 0);
    push_access(1'b0, 32'h0000_5000, 0);
    push_access(1'b1, 32'h0000_6000, 0);
    // No-write-allocate store miss.
    push_cfg(CFG_WRITE_ALLOCATE, 4'd0);
    push_access(1'b1, 32'h0000_7000, 0);
    push_access(1'b0, 32'h0000_7000, 0);
    // Out-of-range register values and an unknown register index.
    push_cfg(CFG_OFFSET_WIDTH, 4'd0);
    push_cfg(CFG_INDEX_WIDTH, 4'd15);
    push_cfg(CFG_WAYS_IN_USE, 4'd0);
    push_cfg(CFG_UNUSED_IDX, 4'd15);
    push_access(1'b0, 32'hFFFF_FFFC, 0);
    push_access(1'b1, 32'h1234_5678, 0);
    push_cfg(CFG_OFFSET_WIDTH, 4'd15);
    push_cfg(CFG_WAYS_IN_USE, 4'd15);
    push_cfg(CFG_WRITE_ALLOCATE, 4'd1);
    push_access(1'b1, 32'hFFFF_F000, 0);
    push_access(1'b1, 32'hFFFF_F000, 0);

    // Random segments, each under its own configuration.
    for (int s = 0; s < 12; s++) begin
      gap = s < 4 ? 25 : (s < 8 ? 85 : 0);
      push_cfg(CFG_WRITE_ALLOCATE, 4'($urandom_range(0, 15)));
      push_cfg(CFG_WRITE_BACK, 4'($urandom_range(0, 15)));
      if (s % 3 == 0) begin
        push_cfg(CFG_OFFSET_WIDTH, 4'($urandom_range(0, 15)));
        push_cfg(CFG_INDEX_WIDTH, 4'($urandom_range(0, 15)));
        push_cfg(CFG_WAYS_IN_USE, 4'($urandom_range(0, 15)));
      end else begin
        push_cfg(CFG_OFFSET_WIDTH, 4'($urandom_range(2, 12)));
        push_cfg(CFG_INDEX_WIDTH, 4'($urandom_range(0, 8)));
        push_cfg(CFG_WAYS_IN_USE, 4'($urandom_range(1, 8)));
      end
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(0, 9) == 0) push_access(1'($urandom), $urandom, gap);
        else push_access(1'($urandom), pooled_addr(), gap);
        // The sender holds off until all results are back.
        if (n == 60) pending_q.push_back(drain_it);
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() != 0 || start_i || expected_rsp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (error_count == 0 && expected_rsp_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sacl_pkg.sv
rtl/core/sacl_row_mem.sv
rtl/core/sacl_way_scan.sv
rtl/core/set_assoc_cache_lru_model.sv
rtl/core/sacl_checker.sv
tb/sv/tb_top.sv
